/* sv/mvs_pkg.sv */
package mvs_pkg;

    // Field widths of the request and result items.
    localparam int COORD_W    = 20;
    localparam int PRICE_W    = 30;
    localparam int IDX_W      = 6;
    localparam int DIST_W     = COORD_W + 1;
    localparam int SUM_W      = PRICE_W + 1;
    localparam int COST_W     = DIST_W + SUM_W;
    localparam int TOTAL_W    = 58;

    // Default number of city slots.
    localparam int CITIES_DEF = 32;

    // Cycles from issuing a pair to the cost unit until its cost is visible.
    localparam int PIPE_LAT   = 3;

    // One stored city.
    typedef struct packed {
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [PRICE_W-1:0] station_price;
        logic [PRICE_W-1:0] wire_price;
    } t_city;

    // Candidate edge leaving the cost unit.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx_i;
        logic [IDX_W-1:0]  idx_j;
        logic [COST_W-1:0] cost;
    } t_cand;

endpackage

/* sv/mvs_if.sv */
interface mvs_in_if;
    import mvs_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [PRICE_W-1:0] station_price;
    logic [PRICE_W-1:0] wire_price;
    logic               final_city;

    modport source (output valid, x_pos, y_pos, station_price, wire_price, final_city,
                    input ready);
    modport sink   (input valid, x_pos, y_pos, station_price, wire_price, final_city,
                    output ready);
endinterface

interface mvs_out_if;
    import mvs_pkg::*;

    logic               valid;
    logic               ready;
    logic               is_station;
    logic [IDX_W-1:0]   city_a;
    logic [IDX_W-1:0]   city_b;
    logic [COST_W-1:0]  edge_cost;
    logic [TOTAL_W-1:0] running_total;
    logic               last_edge;

    modport source (output valid, is_station, city_a, city_b, edge_cost, running_total,
                    last_edge, input ready);
    modport sink   (input valid, is_station, city_a, city_b, edge_cost, running_total,
                    last_edge, output ready);
endinterface

/* sv/mvs_cost.sv */
module mvs_cost #(
    parameter int CITIES = mvs_pkg::CITIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [mvs_pkg::IDX_W-1:0] i_wr_addr,
    input  mvs_pkg::t_city            i_wr_data,
    input  logic                      i_rd_valid,
    input  logic [mvs_pkg::IDX_W-1:0] i_rd_i,
    input  logic [mvs_pkg::IDX_W-1:0] i_rd_j,
    input  logic                      i_rd_station,
    output mvs_pkg::t_cand            o_cand
);
    import mvs_pkg::*;

    localparam int AW = (CITIES > 1) ? $clog2(CITIES) : 1;

    t_city               r_mem [CITIES];
    logic [AW-1:0]       rd_addr_j;

    // Stage A: city pair read from the store.
    logic                r_a_valid;
    logic                r_a_st;
    logic [IDX_W-1:0]    r_a_i;
    logic [IDX_W-1:0]    r_a_j;
    t_city               r_a_ci;
    t_city               r_a_cj;

    // Stage B: distance and price sum.
    logic                r_b_valid;
    logic                r_b_st;
    logic [IDX_W-1:0]    r_b_i;
    logic [IDX_W-1:0]    r_b_j;
    logic [DIST_W-1:0]   r_b_dist;
    logic [SUM_W-1:0]    r_b_psum;
    logic [PRICE_W-1:0]  r_b_stat;

    // Stage C: edge cost.
    logic                r_c_valid;
    logic [IDX_W-1:0]    r_c_i;
    logic [IDX_W-1:0]    r_c_j;
    logic [COST_W-1:0]   r_c_cost;

    logic [COORD_W-1:0]  dx;
    logic [COORD_W-1:0]  dy;
    logic [COST_W-1:0]   prod;

    // The virtual node has no store entry; its read address is a don't-care.
    assign rd_addr_j = (i_rd_j < IDX_W'(CITIES)) ? i_rd_j[AW-1:0] : '0;

    // City store with two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr[AW-1:0]] <= i_wr_data;
        end
        r_a_ci <= r_mem[i_rd_i[AW-1:0]];
        r_a_cj <= r_mem[rd_addr_j];
        r_a_st <= i_rd_station;
        r_a_i  <= i_rd_i;
        r_a_j  <= i_rd_j;
    end

    always_comb begin
        dx = (r_a_ci.x_pos > r_a_cj.x_pos) ? r_a_ci.x_pos - r_a_cj.x_pos
                                            : r_a_cj.x_pos - r_a_ci.x_pos;
        dy = (r_a_ci.y_pos > r_a_cj.y_pos) ? r_a_ci.y_pos - r_a_cj.y_pos
                                            : r_a_cj.y_pos - r_a_ci.y_pos;
    end

    always_ff @(posedge i_clk) begin
        r_b_dist <= DIST_W'(dx) + DIST_W'(dy);
        r_b_psum <= SUM_W'(r_a_ci.wire_price) + SUM_W'(r_a_cj.wire_price);
        r_b_stat <= r_a_ci.station_price;
        r_b_st   <= r_a_st;
        r_b_i    <= r_a_i;
        r_b_j    <= r_a_j;
    end

    // The single multiplier of the block.
    assign prod = r_b_dist * r_b_psum;

    always_ff @(posedge i_clk) begin
        r_c_cost <= r_b_st ? COST_W'(r_b_stat) : prod;
        r_c_i    <= r_b_i;
        r_c_j    <= r_b_j;
    end

    // Valid bits travel alongside the payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_rd_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    assign o_cand.valid = r_c_valid;
    assign o_cand.idx_i = r_c_i;
    assign o_cand.idx_j = r_c_j;
    assign o_cand.cost  = r_c_cost;
endmodule

/* sv/mvs_label.sv */
module mvs_label #(
    parameter int CITIES = mvs_pkg::CITIES_DEF
) (
    input  logic                      i_clk,
    input  logic [mvs_pkg::IDX_W-1:0] i_rd_a_addr,
    input  logic [mvs_pkg::IDX_W-1:0] i_rd_b_addr,
    output logic [mvs_pkg::IDX_W-1:0] o_rd_a,
    output logic [mvs_pkg::IDX_W-1:0] o_rd_b,
    input  logic                      i_wr_en,
    input  logic [mvs_pkg::IDX_W-1:0] i_wr_addr,
    input  logic [mvs_pkg::IDX_W-1:0] i_wr_data
);
    import mvs_pkg::*;

    localparam int LAW = $clog2(CITIES + 1);

    logic [IDX_W-1:0] r_mem [CITIES + 1];

    // Component label of every node, the virtual node included.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr[LAW-1:0]] <= i_wr_data;
        end
        o_rd_a <= r_mem[i_rd_a_addr[LAW-1:0]];
        o_rd_b <= r_mem[i_rd_b_addr[LAW-1:0]];
    end
endmodule

/* sv/manhattan_mst_with_virtual_source.sv */
// Minimum spanning tree over up to CITIES cities plus one virtual station node.
//
// Requests arrive on i_city, one city each; every request is taken at once
// while the block is idle. A request with final_city set closes the batch and
// starts the selection; cities beyond CITIES are dropped but still count their
// final mark. The block then drops ready until every result has been produced.
// Results leave on o_edge, one per accepted edge in selection order; the last
// one carries last_edge and the final total. For n cities there are n results.
//
// Each selection round scans all n(n+1)/2 pairs through one cost unit (two store
// reads, one 21 x 31 bit multiplier) at one pair a cycle, then drains it, looks
// up the components and, when the edge joins two parts, hands over the result
// and relabels the component memory. Rounds = n + edges rejected as cycles.
// The batch starts with a label fill. The result register lets the next round
// run while a result waits; a stalled receiver holds the block only when a
// second result is ready.
// Reset (synchronous, active low) empties the batch and clears all handshakes.
module manhattan_mst_with_virtual_source #(
    parameter int CITIES = mvs_pkg::CITIES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mvs_in_if.sink   i_city,
    mvs_out_if.source o_edge
);
    import mvs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_DRAIN = 8'b0000_1000,
        S_FIND  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_MERGE = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_n;
    logic [IDX_W:0]     r_k;
    logic [IDX_W-1:0]   r_si;
    logic [IDX_W-1:0]   r_sj;
    logic [1:0]         r_drain;
    logic [IDX_W-1:0]   r_acc;
    logic [TOTAL_W-1:0] r_total;

    logic               r_found;
    logic [COST_W-1:0]  r_bc;
    logic [IDX_W-1:0]   r_bi;
    logic [IDX_W-1:0]   r_bj;
    logic               r_have_last;
    logic [COST_W-1:0]  r_lc;
    logic [IDX_W-1:0]   r_li;
    logic [IDX_W-1:0]   r_lj;
    logic [IDX_W-1:0]   r_la;
    logic [IDX_W-1:0]   r_lb;
    logic               r_mv;
    logic [IDX_W-1:0]   r_mk;

    logic               r_ov;
    logic               r_o_station;
    logic [IDX_W-1:0]   r_o_a;
    logic [IDX_W-1:0]   r_o_b;
    logic [COST_W-1:0]  r_o_cost;
    logic [TOTAL_W-1:0] r_o_total;
    logic               r_o_last;

    logic               in_go;
    logic               has_room;
    logic               emit_go;
    logic               after_last;
    logic               better;
    logic [IDX_W:0]     n_ext;
    t_city              wr_city;
    t_cand              cand;
    logic [IDX_W-1:0]   lbl_a;
    logic [IDX_W-1:0]   lbl_b;
    logic [IDX_W-1:0]   lbl_rd_a;
    logic               lbl_we;
    logic [IDX_W-1:0]   lbl_waddr;
    logic [IDX_W-1:0]   lbl_wdata;

    assign i_city.ready = (r_state == S_IDLE);
    assign in_go        = i_city.valid && i_city.ready;
    assign has_room     = (r_count < IDX_W'(CITIES));
    assign emit_go      = (r_state == S_EMIT) && (!r_ov || o_edge.ready);
    assign n_ext        = {1'b0, r_n};

    assign wr_city.x_pos         = i_city.x_pos;
    assign wr_city.y_pos         = i_city.y_pos;
    assign wr_city.station_price = i_city.station_price;
    assign wr_city.wire_price    = i_city.wire_price;

    mvs_cost #(.CITIES(CITIES)) u_cost (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (in_go && has_room),
        .i_wr_addr    (r_count),
        .i_wr_data    (wr_city),
        .i_rd_valid   (r_state == S_SCAN),
        .i_rd_i       (r_si),
        .i_rd_j       (r_sj),
        .i_rd_station (r_sj == r_n),
        .o_cand       (cand)
    );

    // Label port A serves the lookup and the relabel sweep.
    assign lbl_rd_a = (r_state == S_MERGE) ? r_k[IDX_W-1:0] : r_bi;

    always_comb begin
        lbl_we    = 1'b0;
        lbl_waddr = r_mk;
        lbl_wdata = r_lb;
        if (r_state == S_INIT) begin
            lbl_we    = 1'b1;
            lbl_waddr = r_k[IDX_W-1:0];
            lbl_wdata = r_k[IDX_W-1:0];
        end else if (r_state == S_MERGE) begin
            lbl_we    = r_mv && (lbl_a == r_la);
        end
    end

    mvs_label #(.CITIES(CITIES)) u_label (
        .i_clk       (i_clk),
        .i_rd_a_addr (lbl_rd_a),
        .i_rd_b_addr (r_bj),
        .o_rd_a      (lbl_a),
        .o_rd_b      (lbl_b),
        .i_wr_en     (lbl_we),
        .i_wr_addr   (lbl_waddr),
        .i_wr_data   (lbl_wdata)
    );

    // A candidate must come after the last selected edge in selection order:
    // higher cost, or equal cost and a smaller (i,j) pair.
    always_comb begin
        after_last = !r_have_last || (cand.cost > r_lc) ||
                     ((cand.cost == r_lc) &&
                      ((cand.idx_i < r_li) || ((cand.idx_i == r_li) && (cand.idx_j < r_lj))));
        // Pairs come in ascending order, so an equal cost replaces the best.
        better     = !r_found || (cand.cost <= r_bc);
    end

    // Best candidate of the running scan.
    always_ff @(posedge i_clk) begin
        if (cand.valid && after_last && better) begin
            r_bc <= cand.cost;
            r_bi <= cand.idx_i;
            r_bj <= cand.idx_j;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_si        <= '0;
            r_sj        <= '0;
            r_drain     <= '0;
            r_acc       <= '0;
            r_total     <= '0;
            r_found     <= 1'b0;
            r_have_last <= 1'b0;
            r_mv        <= 1'b0;
        end else begin
            if (cand.valid && after_last) begin
                r_found <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_go) begin
                        if (has_room) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_city.final_city) begin
                            r_n     <= has_room ? r_count + 1'b1 : r_count;
                            r_k     <= '0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == n_ext) begin
                        r_acc       <= '0;
                        r_total     <= '0;
                        r_have_last <= 1'b0;
                        r_found     <= 1'b0;
                        r_si        <= '0;
                        r_sj        <= IDX_W'(1);
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_sj == r_n) begin
                        if (r_si == r_n - 1'b1) begin
                            r_drain <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_si <= r_si + 1'b1;
                            r_sj <= r_si + IDX_W'(2);
                        end
                    end else begin
                        r_sj <= r_sj + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (r_drain == 2'(PIPE_LAT - 1)) begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_la        <= lbl_a;
                    r_lb        <= lbl_b;
                    r_lc        <= r_bc;
                    r_li        <= r_bi;
                    r_lj        <= r_bj;
                    r_have_last <= 1'b1;
                    if (lbl_a == lbl_b) begin
                        // Edge closes a cycle: next round.
                        r_found <= 1'b0;
                        r_si    <= '0;
                        r_sj    <= IDX_W'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_total <= r_total + TOTAL_W'(r_bc);
                        r_k     <= '0;
                        r_mv    <= 1'b0;
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    r_mv <= (r_k <= n_ext);
                    r_mk <= r_k[IDX_W-1:0];
                    r_k  <= r_k + 1'b1;
                    if (r_k == n_ext + 1'b1) begin
                        r_acc <= r_acc + 1'b1;
                        if (r_acc + 1'b1 == r_n) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_found <= 1'b0;
                            r_si    <= '0;
                            r_sj    <= IDX_W'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_o_station <= (r_bj == r_n);
            r_o_a       <= r_bi;
            r_o_b       <= (r_bj == r_n) ? '0 : r_bj;
            r_o_cost    <= r_bc;
            r_o_total   <= r_total + TOTAL_W'(r_bc);
            r_o_last    <= (r_acc + 1'b1 == r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_go) begin
            r_ov <= 1'b1;
        end else if (o_edge.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_edge.valid         = r_ov;
    assign o_edge.is_station    = r_o_station;
    assign o_edge.city_a        = r_o_a;
    assign o_edge.city_b        = r_o_b;
    assign o_edge.edge_cost     = r_o_cost;
    assign o_edge.running_total = r_o_total;
    assign o_edge.last_edge     = r_o_last;

    // An edge joining two components is always handed over next.
    a_join_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && lbl_a != lbl_b) |=> (r_state == S_EMIT))
        else $error("joining edge not emitted");

    // Results never outnumber the cities of the batch.
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_INIT) |-> (r_n != '0 && r_acc < r_n))
        else $error("result count out of range");

    // A handed-over result is visible in the next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> r_ov)
        else $error("result register not loaded");

    // A scan ends with a candidate chosen.
    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> r_found)
        else $error("no candidate edge found");
endmodule
